// ===== hdl/ascu_pkg.sv =====
// ----------------------------------------------------------------------------
// ascu_pkg: shared types and constants of the ADC scan converter
// Field widths, register codes, reset values, scale factors and FSM states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ascu_pkg;

    // Converter resolution used for the full-scale value of the battery scaling
    localparam int ADC_BITS_DEF = 12;

    // Field widths
    localparam int SAMPLE_W    = 12;
    localparam int GAIN_W      = 17;
    localparam int FILT_W      = 24;
    localparam int OUT_W       = 16;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 2;

    // Configuration register codes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VREF_CAL    = 2'd0,
        REG_TEMP_LOW    = 2'd1,
        REG_TEMP_HIGH   = 2'd2,
        REG_FILTER_GAIN = 2'd3
    } cfg_reg_t;

    // Register reset values
    localparam int VREF_CAL_RST    = 1520;
    localparam int TEMP_LOW_RST    = 940;
    localparam int TEMP_HIGH_RST   = 1210;
    localparam int FILTER_GAIN_RST = 9830;

    // Scale factors and their widths
    localparam int SUPPLY_REF_MV = 3300;   // supply at which the reference was trimmed
    localparam int SUPPLY_K_W    = 12;
    localparam int BATT_SCALE    = 36300;  // 11:1 divider times 3300 mV
    localparam int BATT_K_W      = 16;
    localparam int BATT_FRAC_W   = 8;      // filter keeps Q.8 mV
    localparam int TEMP_SPAN_CD  = 8000;   // 80 degrees between the two cal points
    localparam int TEMP_K_W      = 13;
    localparam int TEMP_BASE_CD  = 3000;   // low cal point is 30 degrees
    localparam int TEMP_Q_MAX    = 100000;
    localparam int TEMP_Q_W      = 17;
    localparam int Q16_ONE       = 65536;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_LOAD,
        ST_WAIT,
        ST_FILT,
        ST_FWAIT,
        ST_HOLD
    } state_t;

endpackage

// ===== hdl/ascu_scan_if.sv =====
// ----------------------------------------------------------------------------
// ascu_scan_if: input channel of the ADC scan converter
// One item is one scan: battery, reference and temperature sensor samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ascu_scan_if;

    logic                           valid;
    logic                           ready;
    logic [ascu_pkg::SAMPLE_W-1:0]  battery_raw;
    logic [ascu_pkg::SAMPLE_W-1:0]  reference_raw;
    logic [ascu_pkg::SAMPLE_W-1:0]  sensor_raw;

    modport source (
        output valid,
        output battery_raw,
        output reference_raw,
        output sensor_raw,
        input  ready
    );

    modport sink (
        input  valid,
        input  battery_raw,
        input  reference_raw,
        input  sensor_raw,
        output ready
    );

endinterface

// ===== hdl/ascu_result_if.sv =====
// ----------------------------------------------------------------------------
// ascu_result_if: output channel of the ADC scan converter
// One item carries supply, filtered battery voltage and die temperature.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ascu_result_if;

    logic                               valid;
    logic                               ready;
    logic [ascu_pkg::OUT_W-1:0]         supply_mv;
    logic [ascu_pkg::OUT_W-1:0]         battery_mv;
    logic signed [ascu_pkg::OUT_W-1:0]  temp_centideg;
    logic                               temp_cal_error;

    modport source (
        output valid,
        output supply_mv,
        output battery_mv,
        output temp_centideg,
        output temp_cal_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  supply_mv,
        input  battery_mv,
        input  temp_centideg,
        input  temp_cal_error,
        output ready
    );

endinterface

// ===== hdl/ascu_serial_div.sv =====
// ----------------------------------------------------------------------------
// ascu_serial_div: bit-serial restoring divider
// Shifts the dividend in one bit per cycle and shifts one quotient bit out.
// Quotient stays in place until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ascu_serial_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Bring down the next dividend bit and try the subtraction
    always_comb
    begin
        trial    = {rem_reg, q_reg[NUM_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    end

    // Step counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != CNT_W'(1));
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    // Remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[NUM_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

// ===== hdl/ascu_batt_filter.sv =====
// ----------------------------------------------------------------------------
// ascu_batt_filter: first-order low-pass filter for the battery voltage
// Keeps the filtered value in Q.8 mV, seeds it with the first nonzero sample
// and rounds it to whole millivolts with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ascu_batt_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ascu_pkg::FILT_W-1:0]  sample,
    input  logic [ascu_pkg::GAIN_W-1:0]  gain,
    output logic                         done,
    output logic [ascu_pkg::OUT_W-1:0]   battery_mv
);

    localparam int FW   = ascu_pkg::FILT_W;
    localparam int GW   = ascu_pkg::GAIN_W;
    localparam int PW   = FW + 1 + GW + 1;
    localparam int SH_W = 16;

    logic [FW-1:0]        filt_reg;
    logic [FW-1:0]        filt_next;
    logic [FW-1:0]        now_reg;
    logic signed [FW:0]   diff_reg;
    logic [GW-1:0]        g_reg;
    logic [GW-1:0]        g_sat;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] acc;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 done_reg;
    logic [FW:0]          rnd;

    // Clamp the weight to one
    assign g_sat = (gain > GW'(ascu_pkg::Q16_ONE)) ? GW'(ascu_pkg::Q16_ONE) : gain;

    // filt*(1-g) + now*g rewritten as filt + (now-filt)*g, then round
    always_comb
    begin
        acc = $signed({3'b000, filt_reg, 16'h0000}) + prod_reg
            + $signed(PW'(32768));
        if (filt_reg == '0)
        begin
            filt_next = now_reg;
        end
        else
        begin
            filt_next = acc[FW+SH_W-1:SH_W];
        end
    end

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
            filt_reg <= '0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
            if (v2_reg)
            begin
                filt_reg <= filt_next;
            end
        end
    end

    // Capture the sample, form the difference, then the weighted product
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            now_reg  <= sample;
            diff_reg <= $signed({1'b0, sample}) - $signed({1'b0, filt_reg});
            g_reg    <= g_sat;
        end
        if (v1_reg)
        begin
            prod_reg <= diff_reg * $signed({1'b0, g_reg});
        end
    end

    // Round to whole millivolts and saturate
    assign rnd        = {1'b0, filt_reg} + (FW + 1)'(128);
    assign battery_mv = rnd[FW] ? '1 : rnd[FW-1:ascu_pkg::BATT_FRAC_W];
    assign done       = done_reg;

endmodule

// ===== hdl/adc_sensor_scan_converter_unit.sv =====
// ----------------------------------------------------------------------------
// adc_sensor_scan_converter_unit: supply, battery and temperature from one scan
// From accepted item to result valid: three multiply steps, the divider load,
// the bit-serial dividers, which form one quotient bit at a time, a wait state
// to see them finish, the filter start, the filter stages and the result load.
// One item at a time, so a new item is taken only once the last one's result
// is loaded; the result register lets the next item in while a result waits.
// Reset restores default calibration and unseeds the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_sensor_scan_converter_unit #(
    parameter int ADC_BITS = ascu_pkg::ADC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ascu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ascu_pkg::CFG_DATA_W-1:0]   cfg_data,
    ascu_scan_if.sink                         scan,
    ascu_result_if.source                     result
);

    localparam int S          = ascu_pkg::SAMPLE_W;
    localparam int OW         = ascu_pkg::OUT_W;
    localparam int SUP_PROD_W = S + ascu_pkg::SUPPLY_K_W;
    localparam int SUP_NUM_W  = SUP_PROD_W + 1;
    localparam int BC_W       = 2 * S;
    localparam int BSC_W      = BC_W + ascu_pkg::BATT_K_W;
    localparam int BNUM_W     = BSC_W + ascu_pkg::BATT_FRAC_W;
    localparam int NOW_NUM_W  = BNUM_W + 1;
    localparam int NOW_DEN_W  = S + ADC_BITS;
    localparam int TNUM_W     = 2 * S + ascu_pkg::TEMP_K_W;
    localparam int TMP_NUM_W  = TNUM_W + 1;
    localparam int TMP_DEN_W  = 2 * S;
    localparam int QW         = ascu_pkg::TEMP_Q_W;
    localparam int TSUM_W     = QW + 2;

    // Configuration registers
    logic [S-1:0]                  vref_cal_reg;
    logic [S-1:0]                  temp_low_reg;
    logic [S-1:0]                  temp_high_reg;
    logic [ascu_pkg::GAIN_W-1:0]   gain_reg;

    // Sequencer
    ascu_pkg::state_t state_reg;
    ascu_pkg::state_t state_next;
    logic             in_accept;
    logic             out_free;
    logic             div_start;
    logic             flt_start;
    logic             res_load;
    logic             sup_busy;
    logic             now_busy;
    logic             tmp_busy;
    logic             flt_done;

    // Operand and product registers
    logic [S-1:0]          batt_reg;
    logic [S-1:0]          sens_reg;
    logic [S-1:0]          rnum_reg;
    logic [S-1:0]          rden_reg;
    logic [SUP_PROD_W-1:0] sup_prod_reg;
    logic [BC_W-1:0]       bc_reg;
    logic [BC_W-1:0]       sr_reg;
    logic [BC_W-1:0]       lr_reg;
    logic [TMP_DEN_W-1:0]  tden_reg;
    logic [NOW_DEN_W-1:0]  fsd_reg;
    logic [BNUM_W-1:0]     bnum_reg;
    logic [BC_W-1:0]       d1_mag_reg;
    logic                  d1_neg_reg;
    logic [TNUM_W-1:0]     tnum_reg;
    logic [BSC_W-1:0]      bscaled;
    logic [S-1:0]          cal_span;
    logic                  cal_neg;

    // Divider operands and quotients
    logic [SUP_NUM_W-1:0]  sup_num;
    logic [NOW_NUM_W-1:0]  now_num;
    logic [TMP_NUM_W-1:0]  tmp_num;
    logic [SUP_NUM_W-1:0]  sup_q;
    logic [NOW_NUM_W-1:0]  now_q;
    logic [TMP_NUM_W-1:0]  tmp_q;

    // Result formatting
    logic [ascu_pkg::FILT_W-1:0]  now_sat;
    logic [OW-1:0]                supply_sat;
    logic [OW-1:0]                batt_mv;
    logic [QW-1:0]                tq_clamp;
    logic signed [TSUM_W-1:0]     tsum;
    logic signed [OW-1:0]         temp_sat;
    logic                         cal_equal;

    // Result register
    logic                 res_valid_reg;
    logic [OW-1:0]        res_supply_reg;
    logic [OW-1:0]        res_batt_reg;
    logic signed [OW-1:0] res_temp_reg;
    logic                 res_terr_reg;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vref_cal_reg  <= S'(ascu_pkg::VREF_CAL_RST);
            temp_low_reg  <= S'(ascu_pkg::TEMP_LOW_RST);
            temp_high_reg <= S'(ascu_pkg::TEMP_HIGH_RST);
            gain_reg      <= ascu_pkg::GAIN_W'(ascu_pkg::FILTER_GAIN_RST);
        end
        else if (cfg_we)
        begin
            unique case (ascu_pkg::cfg_reg_t'(cfg_index))
                ascu_pkg::REG_VREF_CAL:    vref_cal_reg  <= cfg_data[S-1:0];
                ascu_pkg::REG_TEMP_LOW:    temp_low_reg  <= cfg_data[S-1:0];
                ascu_pkg::REG_TEMP_HIGH:   temp_high_reg <= cfg_data[S-1:0];
                ascu_pkg::REG_FILTER_GAIN: gain_reg      <= cfg_data[ascu_pkg::GAIN_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    assign in_accept = scan.valid && scan.ready;
    assign out_free  = !res_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ascu_pkg::ST_IDLE:
                if (scan.valid)
                begin
                    state_next = ascu_pkg::ST_MUL1;
                end
            ascu_pkg::ST_MUL1:  state_next = ascu_pkg::ST_MUL2;
            ascu_pkg::ST_MUL2:  state_next = ascu_pkg::ST_MUL3;
            ascu_pkg::ST_MUL3:  state_next = ascu_pkg::ST_LOAD;
            ascu_pkg::ST_LOAD:  state_next = ascu_pkg::ST_WAIT;
            ascu_pkg::ST_WAIT:
                if (!sup_busy && !now_busy && !tmp_busy)
                begin
                    state_next = ascu_pkg::ST_FILT;
                end
            ascu_pkg::ST_FILT:  state_next = ascu_pkg::ST_FWAIT;
            ascu_pkg::ST_FWAIT:
                if (flt_done)
                begin
                    state_next = ascu_pkg::ST_HOLD;
                end
            ascu_pkg::ST_HOLD:
                if (out_free)
                begin
                    state_next = ascu_pkg::ST_IDLE;
                end
            default:            state_next = ascu_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        scan.ready = (state_reg == ascu_pkg::ST_IDLE);
        div_start  = (state_reg == ascu_pkg::ST_LOAD);
        flt_start  = (state_reg == ascu_pkg::ST_FILT);
        res_load   = (state_reg == ascu_pkg::ST_HOLD) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ascu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Operand preparation: one multiply level per state
    // ------------------------------------------------------------------
    assign cal_neg  = (temp_high_reg < temp_low_reg);
    assign cal_span = cal_neg ? (temp_low_reg - temp_high_reg)
                              : (temp_high_reg - temp_low_reg);
    assign bscaled  = bc_reg * ascu_pkg::BATT_K_W'(ascu_pkg::BATT_SCALE);

    always_ff @(posedge clk)
    begin
        // Capture the scan; a zero reference means a ratio of one
        if (in_accept)
        begin
            batt_reg <= scan.battery_raw;
            sens_reg <= scan.sensor_raw;
            if (scan.reference_raw == '0)
            begin
                rnum_reg <= S'(1);
                rden_reg <= S'(1);
            end
            else
            begin
                rnum_reg <= vref_cal_reg;
                rden_reg <= scan.reference_raw;
            end
        end
        if (state_reg == ascu_pkg::ST_MUL1)
        begin
            sup_prod_reg <= rnum_reg * ascu_pkg::SUPPLY_K_W'(ascu_pkg::SUPPLY_REF_MV);
            bc_reg       <= batt_reg * rnum_reg;
            sr_reg       <= sens_reg * rnum_reg;
            lr_reg       <= temp_low_reg * rden_reg;
            tden_reg     <= rden_reg * cal_span;
            // rden * (2^ADC_BITS - 1)
            fsd_reg      <= {rden_reg, ADC_BITS'(0)} - NOW_DEN_W'(rden_reg);
        end
        if (state_reg == ascu_pkg::ST_MUL2)
        begin
            bnum_reg   <= {bscaled, ascu_pkg::BATT_FRAC_W'(0)};
            d1_neg_reg <= (sr_reg < lr_reg);
            d1_mag_reg <= (sr_reg < lr_reg) ? (lr_reg - sr_reg) : (sr_reg - lr_reg);
        end
        if (state_reg == ascu_pkg::ST_MUL3)
        begin
            tnum_reg <= d1_mag_reg * ascu_pkg::TEMP_K_W'(ascu_pkg::TEMP_SPAN_CD);
        end
    end

    // Add half the divisor for round-to-nearest
    assign sup_num = SUP_NUM_W'(sup_prod_reg) + SUP_NUM_W'(rden_reg >> 1);
    assign now_num = NOW_NUM_W'(bnum_reg) + NOW_NUM_W'(fsd_reg >> 1);
    assign tmp_num = TMP_NUM_W'(tnum_reg) + TMP_NUM_W'(tden_reg >> 1);

    // ------------------------------------------------------------------
    // Serial dividers, run side by side
    // ------------------------------------------------------------------
    ascu_serial_div #(
        .NUM_W (SUP_NUM_W),
        .DEN_W (S)
    ) u_div_supply (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sup_num),
        .den   (rden_reg),
        .busy  (sup_busy),
        .quot  (sup_q)
    );

    ascu_serial_div #(
        .NUM_W (NOW_NUM_W),
        .DEN_W (NOW_DEN_W)
    ) u_div_batt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (now_num),
        .den   (fsd_reg),
        .busy  (now_busy),
        .quot  (now_q)
    );

    ascu_serial_div #(
        .NUM_W (TMP_NUM_W),
        .DEN_W (TMP_DEN_W)
    ) u_div_temp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (tmp_num),
        .den   (tden_reg),
        .busy  (tmp_busy),
        .quot  (tmp_q)
    );

    // ------------------------------------------------------------------
    // Battery filter
    // ------------------------------------------------------------------
    assign now_sat = (|now_q[NOW_NUM_W-1:ascu_pkg::FILT_W]) ? '1
                                                          : now_q[ascu_pkg::FILT_W-1:0];

    ascu_batt_filter u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (flt_start),
        .sample     (now_sat),
        .gain       (gain_reg),
        .done       (flt_done),
        .battery_mv (batt_mv)
    );

    // ------------------------------------------------------------------
    // Result formatting and saturation
    // ------------------------------------------------------------------
    assign supply_sat = (|sup_q[SUP_NUM_W-1:OW]) ? '1 : sup_q[OW-1:0];
    assign cal_equal  = (temp_high_reg == temp_low_reg);

    always_comb
    begin
        tq_clamp = (tmp_q > TMP_NUM_W'(ascu_pkg::TEMP_Q_MAX)) ? QW'(ascu_pkg::TEMP_Q_MAX)
                                                              : tmp_q[QW-1:0];
        if (d1_neg_reg ^ cal_neg)
        begin
            tsum = -$signed({2'b00, tq_clamp});
        end
        else
        begin
            tsum = $signed({2'b00, tq_clamp});
        end
        tsum = tsum + $signed(TSUM_W'(ascu_pkg::TEMP_BASE_CD));
        priority if (cal_equal)
        begin
            temp_sat = '0;
        end
        else if (tsum > $signed(TSUM_W'(32767)))
        begin
            temp_sat = 16'sh7FFF;
        end
        else if (tsum < -$signed(TSUM_W'(32768)))
        begin
            temp_sat = 16'sh8000;
        end
        else
        begin
            temp_sat = tsum[OW-1:0];
        end
    end

    // Result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_supply_reg <= supply_sat;
            res_batt_reg   <= batt_mv;
            res_temp_reg   <= temp_sat;
            res_terr_reg   <= cal_equal;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.supply_mv      = res_supply_reg;
    assign result.battery_mv     = res_batt_reg;
    assign result.temp_centideg  = res_temp_reg;
    assign result.temp_cal_error = res_terr_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ascu_pkg::ST_MUL1)
        else $error("accepted item did not start the multiply steps");

    a_div_together: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ascu_pkg::ST_LOAD |=> sup_busy && now_busy && tmp_busy)
        else $error("dividers did not start together");

    a_filter_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        flt_done |-> state_reg == ascu_pkg::ST_FWAIT)
        else $error("filter finished outside its wait state");

    a_cal_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_terr_reg |-> res_temp_reg == 16'sd0)
        else $error("calibration error with nonzero temperature");

endmodule

// ===== dv/ascu_scan_checker.sv =====
// ----------------------------------------------------------------------------
// ascu_scan_checker: result predictor and comparator for the scan converter
// Mirrors the calibration registers from the write port, computes the
// expected supply, filtered battery and temperature for every accepted scan,
// and compares each accepted result field by field against the oldest
// expected reading. The failure count and the number of readings still
// outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ascu_scan_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ascu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ascu_pkg::CFG_DATA_W-1:0]   cfg_data,
    ascu_scan_if                              scan,
    ascu_result_if                            result,
    output int                                fail_count,
    output int                                pending_results
);

    import ascu_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0]        supply_mv;
        logic [OUT_W-1:0]        battery_mv;
        logic signed [OUT_W-1:0] temp_centideg;
        logic                    temp_cal_error;
    } reading_t;

    // Mirrored calibration and filter state
    logic [SAMPLE_W-1:0] vref_cal;
    logic [SAMPLE_W-1:0] cal_low;
    logic [SAMPLE_W-1:0] cal_high;
    logic [GAIN_W-1:0]   gain_q16;
    logic [FILT_W-1:0]   filt_q8;

    reading_t expected_readings[$];

    // Convert one scan and advance the battery filter
    function automatic reading_t convert_scan(input logic [SAMPLE_W-1:0] batt_s,
                                              input logic [SAMPLE_W-1:0] vref_s,
                                              input logic [SAMPLE_W-1:0] sens_s);
        longint batt_l, sens_l, low_l, high_l;
        longint ratio_num, ratio_den, full_scale, div_den;
        longint supply, now_q8, g, filt_l, mv;
        longint num, den, abs_num, abs_den, quot, t;
        bit     neg;
        reading_t r;
        batt_l     = batt_s;
        sens_l     = sens_s;
        low_l      = cal_low;
        high_l     = cal_high;
        full_scale = (longint'(1) << ADC_BITS_DEF) - 1;

        // Supply ratio kept exact; a zero reference reading means nominal supply
        if (vref_s == 0) begin
            ratio_num = 1;
            ratio_den = 1;
        end
        else begin
            ratio_num = vref_cal;
            ratio_den = vref_s;
        end
        supply = (SUPPLY_REF_MV * ratio_num + ratio_den / 2) / ratio_den;
        if (supply > 65535)
            supply = 65535;

        // New battery sample in Q.8 mV, saturated to the filter width
        div_den = full_scale * ratio_den;
        now_q8  = (batt_l * BATT_SCALE * (longint'(1) << BATT_FRAC_W) * ratio_num
                   + div_den / 2) / div_den;
        if (now_q8 > 64'hFF_FFFF)
            now_q8 = 64'hFF_FFFF;

        // Seed on first nonzero value, otherwise blend with Q16 weight
        g = (gain_q16 > Q16_ONE) ? Q16_ONE : gain_q16;
        filt_l = filt_q8;
        if (filt_l == 0)
            filt_l = now_q8;
        else
            filt_l = ((filt_l * (Q16_ONE - g) + now_q8 * g + 32768) >> 16) & 64'hFF_FFFF;
        filt_q8 = filt_l[FILT_W-1:0];
        mv = (filt_l + 128) >> BATT_FRAC_W;
        if (mv > 65535)
            mv = 65535;

        // Two-point temperature line, rounded half away from zero
        if (cal_high == cal_low) begin
            t = 0;
            r.temp_cal_error = 1'b1;
        end
        else begin
            num     = TEMP_SPAN_CD * (sens_l * ratio_num - low_l * ratio_den);
            den     = ratio_den * (high_l - low_l);
            neg     = (num < 0) != (den < 0);
            abs_num = (num < 0) ? -num : num;
            abs_den = (den < 0) ? -den : den;
            quot    = (abs_num + abs_den / 2) / abs_den;
            if (quot > TEMP_Q_MAX)
                quot = TEMP_Q_MAX;
            t = (neg ? -quot : quot) + TEMP_BASE_CD;
            if (t > 32767)
                t = 32767;
            if (t < -32768)
                t = -32768;
            r.temp_cal_error = 1'b0;
        end

        r.supply_mv     = supply[OUT_W-1:0];
        r.battery_mv    = mv[OUT_W-1:0];
        r.temp_centideg = t[OUT_W-1:0];
        return r;
    endfunction

    // Report one field that differs from its prediction
    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got, input bit as_signed);
        if (got !== want) begin
            if (as_signed)
                $display("%0t: %s expected %0d, got %0d", $time, name,
                         $signed(want), $signed(got));
            else
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Sample at the falling edge: a handshake seen here completes at the next rise
    always @(negedge clk or negedge rst_n) begin
        reading_t want;
        if (!rst_n) begin
            vref_cal   = VREF_CAL_RST;
            cal_low    = TEMP_LOW_RST;
            cal_high   = TEMP_HIGH_RST;
            gain_q16   = FILTER_GAIN_RST;
            filt_q8    = '0;
            fail_count = 0;
            expected_readings.delete();
        end
        else begin
            // Mirror register writes
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_VREF_CAL:    vref_cal = cfg_data[SAMPLE_W-1:0];
                    REG_TEMP_LOW:    cal_low  = cfg_data[SAMPLE_W-1:0];
                    REG_TEMP_HIGH:   cal_high = cfg_data[SAMPLE_W-1:0];
                    REG_FILTER_GAIN: gain_q16 = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            // Compare an outgoing item before queuing a new one
            if (result.valid && result.ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: unexpected result item supply %0d battery %0d temp %0d",
                             $time, result.supply_mv, result.battery_mv,
                             $signed(result.temp_centideg));
                    fail_count++;
                end
                else begin
                    want = expected_readings.pop_front();
                    check_field("supply_mv", want.supply_mv, result.supply_mv, 1'b0);
                    check_field("battery_mv", want.battery_mv, result.battery_mv, 1'b0);
                    check_field("temp_centideg", want.temp_centideg,
                                result.temp_centideg, 1'b1);
                    check_field("temp_cal_error", {15'd0, want.temp_cal_error},
                                {15'd0, result.temp_cal_error}, 1'b0);
                end
            end

            if (scan.valid && scan.ready)
                expected_readings.push_back(convert_scan(scan.battery_raw,
                                                         scan.reference_raw,
                                                         scan.sensor_raw));
        end
        pending_results = expected_readings.size();
    end

endmodule

// ===== dv/tb_adc_sensor_scan_converter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_adc_sensor_scan_converter_unit: testbench top of the ADC scan converter
// Drives directed corner scans and several random phases under different
// calibration settings and handshake pressure, while a checker beside the
// block predicts and compares every result. Gives the verdict at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adc_sensor_scan_converter_unit;

    import ascu_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 100;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending_results;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    ascu_scan_if   scan_ch ();
    ascu_result_if res_ch ();

    adc_sensor_scan_converter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scan      (scan_ch),
        .result    (res_ch)
    );

    ascu_scan_checker scan_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .scan            (scan_ch),
        .result          (res_ch),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Stall the result side at the current rate
    always @(posedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    // End the run when no item moves for too long
    always @(negedge clk) begin
        if (rst_n) begin
            if ((scan_ch.valid && scan_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Write all four calibration registers back to back
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] vref,
                                  input logic [CFG_DATA_W-1:0] low,
                                  input logic [CFG_DATA_W-1:0] high,
                                  input logic [CFG_DATA_W-1:0] gain);
        cfg_we    <= 1'b1;
        cfg_index <= REG_VREF_CAL;
        cfg_data  <= vref;
        @(posedge clk);
        cfg_index <= REG_TEMP_LOW;
        cfg_data  <= low;
        @(posedge clk);
        cfg_index <= REG_TEMP_HIGH;
        cfg_data  <= high;
        @(posedge clk);
        cfg_index <= REG_FILTER_GAIN;
        cfg_data  <= gain;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one scan item, with random idle cycles ahead of it
    task automatic send_scan(input logic [SAMPLE_W-1:0] batt,
                             input logic [SAMPLE_W-1:0] vref_s,
                             input logic [SAMPLE_W-1:0] sens);
        while ($urandom_range(0, 99) < idle_pct) begin
            scan_ch.valid         <= 1'b0;
            scan_ch.battery_raw   <= SAMPLE_W'($urandom);
            scan_ch.reference_raw <= SAMPLE_W'($urandom);
            scan_ch.sensor_raw    <= SAMPLE_W'($urandom);
            @(posedge clk);
        end
        scan_ch.valid         <= 1'b1;
        scan_ch.battery_raw   <= batt;
        scan_ch.reference_raw <= vref_s;
        scan_ch.sensor_raw    <= sens;
        @(negedge clk);
        while (!scan_ch.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Drop valid and hold until every result has come back
    task automatic drain();
        scan_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Random scans: a mix of plausible reference readings, corners and random values
    task automatic send_random_scans(input int count);
        logic [SAMPLE_W-1:0] batt, vref_s, sens;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0:       vref_s = '0;
                1:       vref_s = SAMPLE_W'($urandom_range(1, 15));
                2, 3, 4, 5: vref_s = SAMPLE_W'($urandom_range(1200, 1900));
                default: vref_s = SAMPLE_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       batt = '0;
                1:       batt = '1;
                default: batt = SAMPLE_W'($urandom);
            endcase
            if ($urandom_range(0, 9) < 4)
                sens = SAMPLE_W'($urandom_range(800, 1400));
            else
                sens = SAMPLE_W'($urandom);
            send_scan(batt, vref_s, sens);
        end
    endtask

    task automatic run_phase(input int count, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        send_random_scans(count);
        drain();
    endtask

    initial begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_VREF_CAL;
        cfg_data              = '0;
        scan_ch.valid         = 1'b0;
        scan_ch.battery_raw   = '0;
        scan_ch.reference_raw = '0;
        scan_ch.sensor_raw    = '0;
        res_ch.ready          = 1'b0;
        idle_pct              = 0;
        stall_pct             = 0;
        quiet_cycles          = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unseeded zero samples, zero reference, field extremes
        send_scan(12'd0, 12'd1520, 12'd940);
        send_scan(12'd0, 12'd0, 12'd0);
        send_scan(12'd2048, 12'd1520, 12'd940);
        send_scan(12'hFFF, 12'hFFF, 12'hFFF);
        send_scan(12'hFFF, 12'd1, 12'hFFF);
        send_scan(12'd1, 12'd1, 12'd0);
        send_scan(12'd0, 12'hFFF, 12'd0);
        send_scan(12'hFFF, 12'd0, 12'hFFF);
        send_scan(12'd1234, 12'd1520, 12'd1210);
        send_scan(12'hAAA, 12'h555, 12'hAAA);
        send_scan(12'h555, 12'hAAA, 12'h555);
        drain();

        // Directed: equal calibration points and gain above one
        apply_settings(17'd1520, 17'd1000, 17'd1000, 17'h1FFFF);
        send_scan(12'hFFF, 12'd1520, 12'hFFF);
        send_scan(12'd100, 12'd1520, 12'd0);
        send_scan(12'd0, 12'd1520, 12'd2000);
        drain();

        // Directed: steep inverted line pushes temperature to both rails
        apply_settings(17'd1520, 17'd4095, 17'd4094, 17'd65536);
        send_scan(12'd3000, 12'd1520, 12'd0);
        send_scan(12'd3000, 12'd1, 12'hFFF);
        send_scan(12'd3000, 12'd0, 12'hFFF);
        send_scan(12'd0, 12'd1520, 12'd2048);
        send_scan(12'd500, 12'd1520, 12'd2048);
        drain();

        // Random phases under several settings and pressures
        apply_settings(17'd1520, 17'd940, 17'd1210, 17'd9830);
        run_phase(200, 0, 0);
        apply_settings(17'd4095, 17'd0, 17'd4095, 17'd65536);
        run_phase(200, 80, 0);
        apply_settings(17'd0, 17'd4095, 17'd0, 17'd0);
        run_phase(200, 0, 80);
        apply_settings(17'($urandom_range(1000, 2000)), 17'($urandom_range(0, 4095)),
                       17'($urandom_range(0, 4095)), 17'($urandom_range(0, 65536)));
        run_phase(250, 26, 26);
        apply_settings(17'd1520, 17'd2222, 17'd2222, 17'h1FFFF);
        run_phase(100, 0, 0);

        // Full-range settings, with the sender holding off mid-phase
        apply_settings(17'($urandom_range(0, 4095)), 17'($urandom_range(0, 4095)),
                       17'($urandom_range(0, 4095)), 17'($urandom_range(0, 65536)));
        run_phase(50, 26, 26);
        run_phase(50, 0, 0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== adc_sensor_scan_converter_unit.f =====
hdl/ascu_pkg.sv
hdl/ascu_scan_if.sv
hdl/ascu_result_if.sv
hdl/ascu_serial_div.sv
hdl/ascu_batt_filter.sv
hdl/adc_sensor_scan_converter_unit.sv
dv/ascu_scan_checker.sv
dv/tb_adc_sensor_scan_converter_unit.sv
